// ----- hw/rtl/bfs_pkg.sv -----
// ============================================================================
// bfs_pkg
// Shared types and codes for the streaming box mean filter.
// ============================================================================
package bfs_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_WINDOW = 2'd2;

  localparam int unsigned CFG_DATA_BITS = 13;

  // back end sequencer
  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_WAIT,
    B_DIV
  } back_state_t;

  // front -> back task control
  typedef struct packed {
    logic valid;
    logic interior;
    logic last;
  } task_ctl_t;

  // back -> front status
  typedef struct packed {
    logic busy;
    logic out_full;
  } back_stat_t;

endpackage

// ----- hw/rtl/box_filter_stream_top.sv -----
// ============================================================================
// box_filter_stream_top
// Streaming K x K box mean filter over a raster-order grey frame.
// ============================================================================
//
//  channel  direction  handshake           payload
//  -------  ---------  ------------------  ---------------------------------
//  cfg      in         cfg_we              cfg_index, cfg_wdata
//  in       in         in_push / in_full   in_operation, in_pixel
//  out      out        out_pop / out_empty out_pixel, out_frame_last
//
//  A beat that causes no result leaves in_full low. A beat that releases an
//  output pixel keeps in_full high after it through one task handoff,
//  N delay line reads (K*K interior, 1 passed through), one read latency
//  state and SW = 14 (default) serial divider steps.
//  Reset is synchronous, active low; no clearing pass, the delay line is
//  never read before it is written within a frame.
//  Up to two results queue at the output; with both slots taken in_full
//  stays high until out_pop frees one.
//
module box_filter_stream_top #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_WINDOW = 7,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [bfs_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  // pixel input
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_operation,
  input  logic [PIXEL_BITS-1:0]             in_pixel,
  // filtered output
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [PIXEL_BITS-1:0]             out_pixel,
  output logic                              out_frame_last
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RSW = $clog2(MAX_WINDOW);
  localparam int unsigned KW  = $clog2(MAX_WINDOW + 1);

  // delay line write from the front end
  logic                  wr_en;
  logic [RSW+CW-1:0]     wr_addr;
  logic [PIXEL_BITS-1:0] wr_data;

  // one-deep task slot between front and back
  bfs_pkg::task_ctl_t    task_ctl;
  logic [RSW-1:0]        task_rslot;
  logic [CW-1:0]         task_col;
  logic [KW-1:0]         task_k;
  logic                  task_take;
  bfs_pkg::back_stat_t   stat;

  // front: positions, scheduling, delay line writes
  bfs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_operation (in_operation),
    .in_pixel     (in_pixel),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .task_ctl     (task_ctl),
    .task_rslot   (task_rslot),
    .task_col     (task_col),
    .task_k       (task_k),
    .task_take    (task_take),
    .stat         (stat)
  );

  // back: window sum, divide, result queue
  bfs_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .task_ctl       (task_ctl),
    .task_rslot     (task_rslot),
    .task_col       (task_col),
    .task_k         (task_k),
    .task_take      (task_take),
    .stat           (stat),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_pixel      (out_pixel),
    .out_frame_last (out_frame_last)
  );

endmodule

// ----- hw/rtl/bfs_front.sv -----
// ============================================================================
// bfs_front
// Config registers, raster position tracking, delay line writes and output
// scheduling; issues one task per due output pixel.
// ============================================================================
module bfs_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_WINDOW = 7,
  parameter int unsigned PIXEL_BITS = 8,
  localparam int unsigned CW  = $clog2(MAX_WIDTH),
  localparam int unsigned RSW = $clog2(MAX_WINDOW),
  localparam int unsigned KW  = $clog2(MAX_WINDOW + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [bfs_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic                               in_operation,
  input  logic [PIXEL_BITS-1:0]              in_pixel,
  output logic                               wr_en,
  output logic [RSW+CW-1:0]                  wr_addr,
  output logic [PIXEL_BITS-1:0]              wr_data,
  output bfs_pkg::task_ctl_t                 task_ctl,
  output logic [RSW-1:0]                     task_rslot,
  output logic [CW-1:0]                      task_col,
  output logic [KW-1:0]                      task_k,
  input  logic                               task_take,
  input  bfs_pkg::back_stat_t                stat
);

  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [2:0]  window_r;

  logic [10:0]   w_eff;
  logic [12:0]   h_eff;
  logic [KW-1:0] k_eff, hk, m, d;
  logic [23:0]   total, delay;

  logic [23:0]    in_pos_r, in_pos_nxt, out_pos_r, out_pos_nxt, in_pos_inc;
  logic [10:0]    in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [12:0]    out_row_r, out_row_nxt;
  logic [RSW-1:0] in_rs_r, in_rs_nxt, out_rs_r, out_rs_nxt;

  bfs_pkg::task_ctl_t task_r, task_nxt;
  logic [RSW-1:0] t_rs_r;
  logic [CW-1:0]  t_col_r;
  logic [KW-1:0]  t_k_r;

  logic acc, in_fire, emit, last, interior;

  always_comb begin
    if (width_r == 11'd0) begin
      w_eff = 11'd1;
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = 11'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r == 13'd0) ? 13'd1 : height_r;
    if (window_r == 3'd0) begin
      k_eff = KW'(1);
    end else if (32'(window_r) > MAX_WINDOW) begin
      k_eff = KW'(MAX_WINDOW);
    end else begin
      k_eff = KW'(window_r);
    end
  end

  assign hk    = k_eff >> 1;
  assign m     = KW'((KW+1)'(k_eff) + (KW+1)'(1) >> 1);
  assign d     = k_eff - KW'(1) - hk;
  assign total = 24'(w_eff) * 24'(h_eff);
  assign delay = 24'(d) * (24'(w_eff) + 24'd1);

  assign interior = !((14'(out_row_r) < 14'(m)) ||
                      (14'(out_row_r) + 14'(m) >= 14'(h_eff)) ||
                      (12'(out_col_r) < 12'(m)) ||
                      (12'(out_col_r) + 12'(m) >= 12'(w_eff)));

  assign in_full    = task_r.valid | stat.busy | stat.out_full;
  assign acc        = in_push & ~in_full;
  assign in_fire    = acc & ~in_operation & (in_pos_r < total);
  assign in_pos_inc = in_pos_r + 24'(in_fire);
  assign emit       = acc & (out_pos_r < total) &
                      ((in_pos_inc >= total) || (in_pos_inc - out_pos_r > delay));
  assign last       = (out_pos_r + 24'd1 == total);

  assign wr_en   = in_fire;
  assign wr_addr = {in_rs_r, CW'(in_col_r)};
  assign wr_data = in_pixel;

  always_comb begin
    in_pos_nxt  = in_pos_r;
    in_col_nxt  = in_col_r;
    in_rs_nxt   = in_rs_r;
    out_pos_nxt = out_pos_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    out_rs_nxt  = out_rs_r;
    task_nxt    = task_r;
    if (task_take) begin
      task_nxt.valid = 1'b0;
    end
    if (emit) begin
      task_nxt.valid    = 1'b1;
      task_nxt.interior = interior;
      task_nxt.last     = last;
    end
    if (cfg_we || (emit && last)) begin
      in_pos_nxt  = '0;
      in_col_nxt  = '0;
      in_rs_nxt   = '0;
      out_pos_nxt = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      out_rs_nxt  = '0;
    end else begin
      if (in_fire) begin
        in_pos_nxt = in_pos_inc;
        if (in_col_r == w_eff - 11'd1) begin
          in_col_nxt = '0;
          in_rs_nxt  = (in_rs_r == RSW'(MAX_WINDOW - 1)) ? '0 : in_rs_r + RSW'(1);
        end else begin
          in_col_nxt = in_col_r + 11'd1;
        end
      end
      if (emit) begin
        out_pos_nxt = out_pos_r + 24'd1;
        if (out_col_r == w_eff - 11'd1) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 13'd1;
          out_rs_nxt  = (out_rs_r == RSW'(MAX_WINDOW - 1)) ? '0 : out_rs_r + RSW'(1);
        end else begin
          out_col_nxt = out_col_r + 11'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= 11'd640;
      height_r  <= 13'd480;
      window_r  <= 3'd3;
      in_pos_r  <= '0;
      in_col_r  <= '0;
      in_rs_r   <= '0;
      out_pos_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      out_rs_r  <= '0;
      task_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bfs_pkg::CFG_WIDTH:  width_r  <= cfg_wdata[10:0];
          bfs_pkg::CFG_HEIGHT: height_r <= cfg_wdata[12:0];
          bfs_pkg::CFG_WINDOW: window_r <= cfg_wdata[2:0];
          default: ;
        endcase
      end
      in_pos_r  <= (cfg_we && cfg_index > bfs_pkg::CFG_WINDOW) ? in_pos_r  : in_pos_nxt;
      in_col_r  <= (cfg_we && cfg_index > bfs_pkg::CFG_WINDOW) ? in_col_r  : in_col_nxt;
      in_rs_r   <= (cfg_we && cfg_index > bfs_pkg::CFG_WINDOW) ? in_rs_r   : in_rs_nxt;
      out_pos_r <= (cfg_we && cfg_index > bfs_pkg::CFG_WINDOW) ? out_pos_r : out_pos_nxt;
      out_col_r <= (cfg_we && cfg_index > bfs_pkg::CFG_WINDOW) ? out_col_r : out_col_nxt;
      out_row_r <= (cfg_we && cfg_index > bfs_pkg::CFG_WINDOW) ? out_row_r : out_row_nxt;
      out_rs_r  <= (cfg_we && cfg_index > bfs_pkg::CFG_WINDOW) ? out_rs_r  : out_rs_nxt;
      task_r    <= task_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      t_rs_r  <= out_rs_r;
      t_col_r <= CW'(out_col_r);
      t_k_r   <= k_eff;
    end
  end

  assign task_ctl   = task_r;
  assign task_rslot = t_rs_r;
  assign task_col   = t_col_r;
  assign task_k     = t_k_r;

endmodule

// ----- hw/rtl/bfs_back.sv -----
// ============================================================================
// bfs_back
// Delay line memory, window accumulation over K*K reads (one read for a
// border pixel), serial divide by that count and a two-entry result queue.
// ============================================================================
module bfs_back #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_WINDOW = 7,
  parameter int unsigned PIXEL_BITS = 8,
  localparam int unsigned CW  = $clog2(MAX_WIDTH),
  localparam int unsigned RSW = $clog2(MAX_WINDOW),
  localparam int unsigned KW  = $clog2(MAX_WINDOW + 1),
  localparam int unsigned KKW = $clog2(MAX_WINDOW * MAX_WINDOW + 1),
  localparam int unsigned SW  = $clog2(MAX_WINDOW * MAX_WINDOW * ((1 << PIXEL_BITS) - 1) + 1),
  localparam int unsigned DCW = $clog2(SW),
  localparam int unsigned DEPTH = MAX_WINDOW << CW
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  logic [RSW+CW-1:0]       wr_addr,
  input  logic [PIXEL_BITS-1:0]   wr_data,
  input  bfs_pkg::task_ctl_t      task_ctl,
  input  logic [RSW-1:0]          task_rslot,
  input  logic [CW-1:0]           task_col,
  input  logic [KW-1:0]           task_k,
  output logic                    task_take,
  output bfs_pkg::back_stat_t     stat,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [PIXEL_BITS-1:0]   out_pixel,
  output logic                    out_frame_last
);

  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [PIXEL_BITS-1:0] rdata_r;
  logic [RSW+CW-1:0]     rd_addr;

  bfs_pkg::back_state_t state_r, state_nxt;
  logic [RSW-1:0] rs_r, rs_nxt, rs0;
  logic [CW-1:0]  c_r, c_nxt, c0_r, c0_nxt, c0;
  logic [KW-1:0]  rcnt_r, rcnt_nxt, ccnt_r, ccnt_nxt, n_r, n_nxt, hk;
  logic [KKW-1:0] kk_r, kk_nxt;
  logic           last_r, last_nxt, rv_r, rv_nxt;
  logic [SW-1:0]  sum_r, sum_nxt, dq_r, dq_nxt, sum_in;
  logic [KKW-1:0] rem_r, rem_nxt;
  logic [KKW:0]   trial;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic           push;

  logic [PIXEL_BITS-1:0] qp_r [2];
  logic                  ql_r [2];
  logic                  wp_r, rp_r;
  logic [1:0]            cnt_r;
  logic                  pop;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  assign rd_addr = {rs_r, c_r};
  assign hk      = task_k >> 1;
  assign c0      = task_ctl.interior ? task_col - CW'(hk) : task_col;

  always_comb begin
    if (!task_ctl.interior) begin
      rs0 = task_rslot;
    end else if ((RSW+1)'(task_rslot) >= (RSW+1)'(hk)) begin
      rs0 = RSW'((RSW+1)'(task_rslot) - (RSW+1)'(hk));
    end else begin
      rs0 = RSW'((RSW+1)'(task_rslot) + (RSW+1)'(MAX_WINDOW) - (RSW+1)'(hk));
    end
  end

  assign sum_in = sum_r + SW'(rdata_r);
  assign trial  = {rem_r, dq_r[SW-1]};

  always_comb begin
    state_nxt = state_r;
    rs_nxt    = rs_r;
    c_nxt     = c_r;
    c0_nxt    = c0_r;
    rcnt_nxt  = rcnt_r;
    ccnt_nxt  = ccnt_r;
    n_nxt     = n_r;
    kk_nxt    = kk_r;
    last_nxt  = last_r;
    rv_nxt    = 1'b0;
    sum_nxt   = sum_r;
    dq_nxt    = dq_r;
    rem_nxt   = rem_r;
    dcnt_nxt  = dcnt_r;
    task_take = 1'b0;
    push      = 1'b0;
    case (state_r)
      bfs_pkg::B_IDLE: begin
        if (task_ctl.valid) begin
          task_take = 1'b1;
          rs_nxt    = rs0;
          c_nxt     = c0;
          c0_nxt    = c0;
          rcnt_nxt  = '0;
          ccnt_nxt  = '0;
          n_nxt     = task_ctl.interior ? task_k : KW'(1);
          kk_nxt    = task_ctl.interior ? KKW'(task_k) * KKW'(task_k) : KKW'(1);
          last_nxt  = task_ctl.last;
          sum_nxt   = '0;
          state_nxt = bfs_pkg::B_READ;
        end
      end
      bfs_pkg::B_READ: begin
        rv_nxt = 1'b1;
        if (rv_r) begin
          sum_nxt = sum_in;
        end
        if (ccnt_r == n_r - KW'(1)) begin
          ccnt_nxt = '0;
          c_nxt    = c0_r;
          rcnt_nxt = rcnt_r + KW'(1);
          rs_nxt   = (rs_r == RSW'(MAX_WINDOW - 1)) ? '0 : rs_r + RSW'(1);
          if (rcnt_r == n_r - KW'(1)) begin
            state_nxt = bfs_pkg::B_WAIT;
          end
        end else begin
          ccnt_nxt = ccnt_r + KW'(1);
          c_nxt    = c_r + CW'(1);
        end
      end
      bfs_pkg::B_WAIT: begin
        dq_nxt    = sum_in;
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = bfs_pkg::B_DIV;
      end
      bfs_pkg::B_DIV: begin
        if (trial >= (KKW+1)'(kk_r)) begin
          rem_nxt = KKW'(trial - (KKW+1)'(kk_r));
          dq_nxt  = {dq_r[SW-2:0], 1'b1};
        end else begin
          rem_nxt = KKW'(trial);
          dq_nxt  = {dq_r[SW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(SW - 1)) begin
          push      = 1'b1;
          state_nxt = bfs_pkg::B_IDLE;
        end
      end
      default: state_nxt = bfs_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfs_pkg::B_IDLE;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rs_r   <= rs_nxt;
    c_r    <= c_nxt;
    c0_r   <= c0_nxt;
    rcnt_r <= rcnt_nxt;
    ccnt_r <= ccnt_nxt;
    n_r    <= n_nxt;
    kk_r   <= kk_nxt;
    last_r <= last_nxt;
    sum_r  <= sum_nxt;
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    dcnt_r <= dcnt_nxt;
  end

  // result queue
  assign pop = out_pop & (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qp_r[wp_r] <= PIXEL_BITS'(dq_nxt);
      ql_r[wp_r] <= last_r;
    end
  end

  assign out_empty      = (cnt_r == 2'd0);
  assign out_pixel      = qp_r[rp_r];
  assign out_frame_last = ql_r[rp_r];

  assign stat.busy     = (state_r != bfs_pkg::B_IDLE);
  assign stat.out_full = (cnt_r == 2'd2);

endmodule

// ----- hw/rtl/bfs_checker.sv -----
// ============================================================================
// bfs_checker
// Port-level checks on reset state and result hold-off.
// ============================================================================
module bfs_checker #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_full,
  input logic                  out_empty,
  input logic                  out_pop,
  input logic [PIXEL_BITS-1:0] out_pixel,
  input logic                  out_frame_last
);

  // reset leaves the block ready with no result queued
  a_reset_state: assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("bad state after reset");

  // a result that is not popped does not disappear
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("result lost");

  // a stalled result holds its payload
  a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> ($stable(out_pixel) && $stable(out_frame_last)))
    else $error("stalled result changed");

endmodule

bind box_filter_stream_top bfs_checker #(.PIXEL_BITS(PIXEL_BITS)) u_bfs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_full        (in_full),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_pixel      (out_pixel),
  .out_frame_last (out_frame_last)
);
